/* rtl/core/yuv420_block_to_bgr_core_macros.svh */
// ----------------------------------------------------------------------------
// yuv420_block_to_bgr_core_macros
// Assertion helpers shared by the color conversion core.
// ----------------------------------------------------------------------------
`ifndef YUV420_BLOCK_TO_BGR_CORE_MACROS_SVH
`define YUV420_BLOCK_TO_BGR_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define Y2B_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("y2b same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define Y2B_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("y2b next-cycle check failed");

`endif

/* rtl/core/y2b_pkg.sv */
// ----------------------------------------------------------------------------
// y2b_pkg
// Types and fixed-point coefficients for the 4:2:0 block to BGR converter.
// ----------------------------------------------------------------------------
package y2b_pkg;

   // Signed channel sums span roughly -17M .. +35M: 27 bits cover them
   localparam int SumWidth = 27;

   typedef logic signed [SumWidth-1:0] sum_type;
   typedef logic signed [8:0]          chroma_type;

   // Chroma offsets shared by the four pixels of a block
   typedef struct packed {
      sum_type blue;
      sum_type green;
      sum_type red;
   } offset_type;

   // One converted pixel
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // BT.601 studio-range coefficients, 16 fraction bits
   localparam sum_type LumaGain = 27'sd76310;
   localparam sum_type RedV     = 27'sd104635;
   localparam sum_type GreenU   = -27'sd25690;
   localparam sum_type GreenV   = -27'sd53294;
   localparam sum_type BlueU    = 27'sd132278;

   localparam chroma_type ChromaMid  = 9'sd128;
   localparam logic [7:0] LumaFloor  = 8'd16;
   localparam sum_type    SatHigh    = 27'sh0ffffff;
   localparam sum_type    SatLow     = 27'sh000ffff;

endpackage

/* rtl/core/yuv420_block_to_bgr_core.sv */
// ----------------------------------------------------------------------------
// yuv420_block_to_bgr_core
// Converts a 2x2 block of planar 4:2:0 video to four BGR pixels (BT.601).
// ----------------------------------------------------------------------------
// The core takes one 2x2 block per clock and returns its four pixels, once
// through both register stages, on rsp_valid for exactly one cycle.
// It is fully pipelined: the coefficient multiplies sit in the first stage
// (one chroma unit and four luma lanes), the add and saturate in the second,
// and the merged result register drives the response ports. busy stays low,
// so a request is taken in every cycle that start is high. The receiver
// cannot stall, and none is needed: every request yields exactly one
// response at a fixed latency. There is no configuration and no state
// beyond the pipeline.
// ----------------------------------------------------------------------------
`include "yuv420_block_to_bgr_core_macros.svh"

module yuv420_block_to_bgr_core import y2b_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_luma_top_left,
   input  logic [7:0] req_luma_top_right,
   input  logic [7:0] req_luma_bottom_left,
   input  logic [7:0] req_luma_bottom_right,
   input  logic [7:0] req_chroma_u,
   input  logic [7:0] req_chroma_v,
   output logic       rsp_valid,
   output logic [7:0] rsp_top_left_blue,
   output logic [7:0] rsp_top_left_green,
   output logic [7:0] rsp_top_left_red,
   output logic [7:0] rsp_top_right_blue,
   output logic [7:0] rsp_top_right_green,
   output logic [7:0] rsp_top_right_red,
   output logic [7:0] rsp_bottom_left_blue,
   output logic [7:0] rsp_bottom_left_green,
   output logic [7:0] rsp_bottom_left_red,
   output logic [7:0] rsp_bottom_right_blue,
   output logic [7:0] rsp_bottom_right_green,
   output logic [7:0] rsp_bottom_right_red
);

   localparam int Lanes = 4;

   logic       accept;
   logic       stage_valid_in;
   logic       stage_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_valid_ff;
   logic [7:0] lane_luma [Lanes];
   offset_type offset;
   pixel_type  lane_pixel [Lanes];
   pixel_type  merge_ff [Lanes];

   // The pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign lane_luma[0] = req_luma_top_left;
   assign lane_luma[1] = req_luma_top_right;
   assign lane_luma[2] = req_luma_bottom_left;
   assign lane_luma[3] = req_luma_bottom_right;

   // Shared chroma offsets
   y2b_chroma u_chroma (
      .clock    (clock),
      .chroma_u (req_chroma_u),
      .chroma_v (req_chroma_v),
      .offset   (offset)
   );

   // One lane per pixel of the block
   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      y2b_lane u_lane (
         .clock  (clock),
         .luma   (lane_luma[g]),
         .offset (offset),
         .pixel  (lane_pixel[g])
      );
   end

   // Advance the request valid alongside the data
   assign stage_valid_in = accept;
   assign rsp_valid_in   = stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Merge the lane pixels into the response register
   always_ff @(posedge clock) begin
      for (int i = 0; i < Lanes; i++) begin
         merge_ff[i] <= lane_pixel[i];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_top_left_blue      = merge_ff[0].blue;
   assign rsp_top_left_green     = merge_ff[0].green;
   assign rsp_top_left_red       = merge_ff[0].red;
   assign rsp_top_right_blue     = merge_ff[1].blue;
   assign rsp_top_right_green    = merge_ff[1].green;
   assign rsp_top_right_red      = merge_ff[1].red;
   assign rsp_bottom_left_blue   = merge_ff[2].blue;
   assign rsp_bottom_left_green  = merge_ff[2].green;
   assign rsp_bottom_left_red    = merge_ff[2].red;
   assign rsp_bottom_right_blue  = merge_ff[3].blue;
   assign rsp_bottom_right_green = merge_ff[3].green;
   assign rsp_bottom_right_red   = merge_ff[3].red;

   // Every accepted request reaches the lane stage, then the response
   `Y2B_ASSERT_NEXT(a_accept_to_stage, clock, reset, accept, stage_valid_ff)
   `Y2B_ASSERT_NEXT(a_stage_to_rsp, clock, reset, stage_valid_ff, rsp_valid_ff)
   // No response appears unless the lane stage held a valid request before it
   `Y2B_ASSERT_SAME(a_rsp_has_source, clock, reset, rsp_valid_ff, $past(stage_valid_ff))

endmodule

/* rtl/core/y2b_chroma.sv */
// ----------------------------------------------------------------------------
// y2b_chroma
// Forms the blue, green and red chroma offsets shared by a block's pixels.
// ----------------------------------------------------------------------------
module y2b_chroma import y2b_pkg::*; (
   input  logic       clock,
   input  logic [7:0] chroma_u,
   input  logic [7:0] chroma_v,
   output offset_type offset
);

   chroma_type u_s;
   chroma_type v_s;
   offset_type offset_in;
   offset_type offset_ff;

   // Remove the chroma midpoint
   assign u_s = $signed({1'b0, chroma_u}) - ChromaMid;
   assign v_s = $signed({1'b0, chroma_v}) - ChromaMid;

   // Scale by the fixed-point coefficients
   always_comb begin
      offset_in.blue  = BlueU * sum_type'(u_s);
      offset_in.green = (GreenU * sum_type'(u_s)) + (GreenV * sum_type'(v_s));
      offset_in.red   = RedV * sum_type'(v_s);
   end

   // Hold the offsets for the lanes
   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   assign offset = offset_ff;

endmodule

/* rtl/core/y2b_lane.sv */
// ----------------------------------------------------------------------------
// y2b_lane
// Converts one luma sample plus the shared chroma offsets to a BGR pixel.
// ----------------------------------------------------------------------------
module y2b_lane import y2b_pkg::*; (
   input  logic       clock,
   input  logic [7:0] luma,
   input  offset_type offset,
   output pixel_type  pixel
);

   logic [7:0] luma_floor;
   sum_type    base_in;
   sum_type    base_ff;

   // Saturate a channel sum and take its integer byte
   function automatic logic [7:0] clamp_channel(input sum_type s);
      logic [7:0] result;
      if (s > SatHigh) begin
         result = 8'hff;
      end else if (s <= SatLow) begin
         result = 8'h00;
      end else begin
         result = s[23:16];
      end
      return result;
   endfunction

   // Floor luma minus the black level at zero
   assign luma_floor = (luma < LumaFloor) ? 8'd0 : (luma - LumaFloor);
   assign base_in    = LumaGain * sum_type'({1'b0, luma_floor});

   // Hold the luma term alongside the chroma offsets
   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   // Add and saturate each channel
   always_comb begin
      pixel.blue  = clamp_channel(base_ff + offset.blue);
      pixel.green = clamp_channel(base_ff + offset.green);
      pixel.red   = clamp_channel(base_ff + offset.red);
   end

endmodule

/* verif/yuv420_block_to_bgr_core_tb.sv */
// ----------------------------------------------------------------------------
// yuv420_block_to_bgr_core_tb
// Self-checking bench for the 4:2:0 block to BGR converter core.
// ----------------------------------------------------------------------------
// Drives 2x2 blocks through the start/busy request port with random gaps and
// back-to-back bursts. A fixed-point BT.601 predictor computes the four
// expected pixels of every accepted request. The response monitor compares
// each strobed result byte by byte against the oldest pending prediction.
// Directed blocks cover the luma floor, saturation at both ends and the
// chroma extremes. Random phases cover the full input range, the studio
// range and the saturation thresholds.
// ----------------------------------------------------------------------------
module yuv420_block_to_bgr_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Twelve result bytes; index = pixel * 3 + channel, channel order B, G, R
   typedef logic [11:0][7:0] bgr_block_type;

   localparam longint LumaGain   = 76310;
   localparam longint RedFromV   = 104635;
   localparam longint GreenFromU = -25690;
   localparam longint GreenFromV = -53294;
   localparam longint BlueFromU  = 132278;
   localparam longint ChromaMid  = 128;
   localparam longint LumaFloor  = 16;
   localparam longint ClipHigh   = 'h0ffffff;
   localparam longint ClipLow    = 'h000ffff;

   localparam int MaxGap       = 11;
   localparam int MaxReported  = 10;
   localparam int DrainLimit   = 1000;
   localparam int PipeSettle   = 8;

   localparam string LaneNames [12] = '{
      "top_left_blue", "top_left_green", "top_left_red",
      "top_right_blue", "top_right_green", "top_right_red",
      "bottom_left_blue", "bottom_left_green", "bottom_left_red",
      "bottom_right_blue", "bottom_right_green", "bottom_right_red"};

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_luma_top_left;
   logic [7:0] req_luma_top_right;
   logic [7:0] req_luma_bottom_left;
   logic [7:0] req_luma_bottom_right;
   logic [7:0] req_chroma_u;
   logic [7:0] req_chroma_v;
   logic       rsp_valid;
   logic [7:0] rsp_top_left_blue;
   logic [7:0] rsp_top_left_green;
   logic [7:0] rsp_top_left_red;
   logic [7:0] rsp_top_right_blue;
   logic [7:0] rsp_top_right_green;
   logic [7:0] rsp_top_right_red;
   logic [7:0] rsp_bottom_left_blue;
   logic [7:0] rsp_bottom_left_green;
   logic [7:0] rsp_bottom_left_red;
   logic [7:0] rsp_bottom_right_blue;
   logic [7:0] rsp_bottom_right_green;
   logic [7:0] rsp_bottom_right_red;

   bgr_block_type pending_pixels [$];
   bgr_block_type rsp_block;
   bgr_block_type wanted_block;

   int  blocks_sent;
   int  blocks_checked;
   int  mismatch_count;
   int  failure_count;
   int  clipped_low;
   int  clipped_high;
   bit  burst_mode;

   yuv420_block_to_bgr_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_luma_top_left      (req_luma_top_left),
      .req_luma_top_right     (req_luma_top_right),
      .req_luma_bottom_left   (req_luma_bottom_left),
      .req_luma_bottom_right  (req_luma_bottom_right),
      .req_chroma_u           (req_chroma_u),
      .req_chroma_v           (req_chroma_v),
      .rsp_valid              (rsp_valid),
      .rsp_top_left_blue      (rsp_top_left_blue),
      .rsp_top_left_green     (rsp_top_left_green),
      .rsp_top_left_red       (rsp_top_left_red),
      .rsp_top_right_blue     (rsp_top_right_blue),
      .rsp_top_right_green    (rsp_top_right_green),
      .rsp_top_right_red      (rsp_top_right_red),
      .rsp_bottom_left_blue   (rsp_bottom_left_blue),
      .rsp_bottom_left_green  (rsp_bottom_left_green),
      .rsp_bottom_left_red    (rsp_bottom_left_red),
      .rsp_bottom_right_blue  (rsp_bottom_right_blue),
      .rsp_bottom_right_green (rsp_bottom_right_green),
      .rsp_bottom_right_red   (rsp_bottom_right_red)
   );

   assign rsp_block = {rsp_bottom_right_red, rsp_bottom_right_green, rsp_bottom_right_blue,
                       rsp_bottom_left_red, rsp_bottom_left_green, rsp_bottom_left_blue,
                       rsp_top_right_red, rsp_top_right_green, rsp_top_right_blue,
                       rsp_top_left_red, rsp_top_left_green, rsp_top_left_blue};

   // Free-running clock, 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reduce one channel sum to a byte: clip low, clip high, else take bits 23..16
   function automatic logic [7:0] clip_channel(input longint sum);
      if (sum > ClipHigh) return 8'hff;
      if (sum <= ClipLow) return 8'h00;
      return sum[23:16];
   endfunction

   // Convert one 2x2 block; lumas[0..3] = top left, top right, bottom left, bottom right
   function automatic bgr_block_type convert_block(input logic [3:0][7:0] lumas,
                                                   input logic [7:0] chroma_u,
                                                   input logic [7:0] chroma_v);
      longint        u;
      longint        v;
      longint        blue_offset;
      longint        green_offset;
      longint        red_offset;
      longint        y;
      longint        base;
      int            p;
      bgr_block_type pixels;
      u = longint'(chroma_u) - ChromaMid;
      v = longint'(chroma_v) - ChromaMid;
      blue_offset  = BlueFromU * u;
      green_offset = GreenFromU * u + GreenFromV * v;
      red_offset   = RedFromV * v;
      for (p = 0; p < 4; p++) begin
         y = longint'(lumas[p]) - LumaFloor;
         if (y < 0) y = 0;
         base = LumaGain * y;
         pixels[p*3+0] = clip_channel(base + blue_offset);
         pixels[p*3+1] = clip_channel(base + green_offset);
         pixels[p*3+2] = clip_channel(base + red_offset);
      end
      return pixels;
   endfunction

   // Present one request, hold it until accepted, then idle for a drawn gap
   task automatic send_block(input logic [7:0] y_tl, input logic [7:0] y_tr,
                             input logic [7:0] y_bl, input logic [7:0] y_br,
                             input logic [7:0] cu, input logic [7:0] cv);
      bgr_block_type predicted;
      int            gap;
      int            k;
      @(negedge clock);
      start                 <= 1'b1;
      req_luma_top_left     <= y_tl;
      req_luma_top_right    <= y_tr;
      req_luma_bottom_left  <= y_bl;
      req_luma_bottom_right <= y_br;
      req_chroma_u          <= cu;
      req_chroma_v          <= cv;
      do @(posedge clock); while (busy);
      predicted = convert_block({y_br, y_bl, y_tr, y_tl}, cu, cv);
      pending_pixels.push_back(predicted);
      blocks_sent++;
      for (k = 0; k < 12; k++) begin
         if (predicted[k] == 8'h00) clipped_low++;
         if (predicted[k] == 8'hff) clipped_high++;
      end
      gap = burst_mode ? 0 : $urandom_range(0, MaxGap);
      // Idle with start low and garbage on the data lines
      repeat (gap) begin
         @(negedge clock);
         start                 <= 1'b0;
         req_luma_top_left     <= 8'($urandom);
         req_luma_top_right    <= 8'($urandom);
         req_luma_bottom_left  <= 8'($urandom);
         req_luma_bottom_right <= 8'($urandom);
         req_chroma_u          <= 8'($urandom);
         req_chroma_v          <= 8'($urandom);
      end
   endtask

   // Release start once no more requests follow
   task automatic idle_request_port();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Flip between bursts and gapped traffic every so often
   task automatic maybe_switch_pacing(input int index);
      if (index % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
   endtask

   // Luma floor, saturation ends and chroma extremes
   task automatic test_directed_corners();
      burst_mode = 1'b0;
      send_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128);
      send_block(8'd15, 8'd16, 8'd17, 8'd18, 8'd128, 8'd128);
      send_block(8'd235, 8'd236, 8'd254, 8'd255, 8'd128, 8'd128);
      send_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
      send_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
      send_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_block(8'd0, 8'd255, 8'd16, 8'd235, 8'd0, 8'd255);
      send_block(8'd0, 8'd255, 8'd16, 8'd235, 8'd255, 8'd0);
      send_block(8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240);
      send_block(8'd126, 8'd126, 8'd126, 8'd126, 8'd16, 8'd16);
      send_block(8'd126, 8'd126, 8'd126, 8'd126, 8'd240, 8'd240);
      send_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd240, 8'd128);
      send_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd240);
      send_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd16, 8'd128);
      send_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd16);
      send_block(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h55, 8'haa);
      send_block(8'haa, 8'h55, 8'hf0, 8'h0f, 8'haa, 8'h55);
      // Back-to-back pair to hit the pipeline at full rate
      burst_mode = 1'b1;
      send_block(8'd1, 8'd2, 8'd4, 8'd8, 8'd127, 8'd129);
      send_block(8'd32, 8'd64, 8'd128, 8'd255, 8'd129, 8'd127);
      burst_mode = 1'b0;
   endtask

   // Uniform random over every field bit
   task automatic test_random_full_range(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         maybe_switch_pacing(i);
         send_block(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      end
   endtask

   // Legal studio-range video: luma 16..235, chroma 16..240
   task automatic test_random_studio_range(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         maybe_switch_pacing(i);
         send_block(8'($urandom_range(16, 235)), 8'($urandom_range(16, 235)),
                    8'($urandom_range(16, 235)), 8'($urandom_range(16, 235)),
                    8'($urandom_range(16, 240)), 8'($urandom_range(16, 240)));
      end
   endtask

   // Lumas near the floor and the top, chroma near neutral: sums land near the clip points
   task automatic test_random_clip_edges(input int count);
      int         i;
      int         p;
      logic [7:0] lumas [4];
      for (i = 0; i < count; i++) begin
         maybe_switch_pacing(i);
         for (p = 0; p < 4; p++)
            lumas[p] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8, 24))
                                                   : 8'($urandom_range(220, 255));
         send_block(lumas[0], lumas[1], lumas[2], lumas[3],
                    8'($urandom_range(112, 144)), 8'($urandom_range(112, 144)));
      end
   endtask

   // Compare every strobed result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            failure_count++;
            $display("[%0t] unexpected response, no request outstanding", $realtime);
         end else begin
            wanted_block = pending_pixels.pop_front();
            blocks_checked++;
            for (int k = 0; k < 12; k++) begin
               if (rsp_block[k] !== wanted_block[k]) begin
                  mismatch_count++;
                  failure_count++;
                  if (mismatch_count <= MaxReported)
                     $display("[%0t] response %0d %s: expected %02h, got %02h",
                              $realtime, blocks_checked, LaneNames[k],
                              wanted_block[k], rsp_block[k]);
               end
            end
         end
      end
   end

   // Run ceiling
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   // Reset, run each test in turn, drain and report
   initial begin
      int drain_cycles;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_luma_top_left     = 8'd0;
      req_luma_top_right    = 8'd0;
      req_luma_bottom_left  = 8'd0;
      req_luma_bottom_right = 8'd0;
      req_chroma_u          = 8'd0;
      req_chroma_v          = 8'd0;
      blocks_sent           = 0;
      blocks_checked        = 0;
      mismatch_count        = 0;
      failure_count         = 0;
      clipped_low           = 0;
      clipped_high          = 0;
      burst_mode            = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_full_range(650);
      test_random_studio_range(500);
      test_random_clip_edges(480);
      idle_request_port();

      // Wait for the last responses, then let the pipeline settle
      drain_cycles = 0;
      while (pending_pixels.size() != 0 && drain_cycles < DrainLimit) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_pixels.size() != 0) begin
         failure_count++;
         $display("%0d responses never arrived", pending_pixels.size());
      end
      repeat (PipeSettle) @(posedge clock);

      $display("sent %0d blocks, checked %0d responses, %0d mismatched bytes",
               blocks_sent, blocks_checked, mismatch_count);
      $display("expected bytes clipped to zero: %0d, clipped to full scale: %0d",
               clipped_low, clipped_high);
      if (failure_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
